FILE: design/cpq_pkg.sv
// Shared types, sizes and codes of the class priority call queue.
package cpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_SERVE   = 2'd1;
  localparam logic [1:0] CMD_DISMISS = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_NOTHING = 2'd3;

  localparam logic [1:0] CLASS_DATA  = 2'd0;
  localparam logic [1:0] CLASS_VOICE = 2'd1;
  localparam logic [1:0] CLASS_EMERG = 2'd2;

  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] sender;
    logic [31:0] receiver;
    logic [15:0] packets;
    logic        show_caller;
    logic        roaming;
  } call_rec_t;

  typedef struct packed {
    logic      insert;
    logic      serve;
    call_rec_t rec;
  } cell_ctrl_t;

endpackage

FILE: design/cpq_req_if.sv
// Command channel of the call queue.
interface cpq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  call_class;
  logic [31:0] sender_id;
  logic [31:0] receiver_id;
  logic [15:0] packet_count;
  logic        show_caller;
  logic        roaming_on;

  modport source (output valid, cmd, call_class, sender_id, receiver_id, packet_count,
                  show_caller, roaming_on, input ready);
  modport sink   (input valid, cmd, call_class, sender_id, receiver_id, packet_count,
                  show_caller, roaming_on, output ready);
endinterface

FILE: design/cpq_rsp_if.sv
// Result channel of the call queue.
interface cpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  out_class;
  logic [31:0] out_sender;
  logic [31:0] out_receiver;
  logic [15:0] out_packets;
  logic        out_show_caller;
  logic        out_roaming;
  logic [4:0]  occupancy;

  modport source (output valid, status, out_class, out_sender, out_receiver, out_packets,
                  out_show_caller, out_roaming, occupancy, input ready);
  modport sink   (input valid, status, out_class, out_sender, out_receiver, out_packets,
                  out_show_caller, out_roaming, occupancy, output ready);
endinterface

FILE: design/class_priority_call_queue_core.sv
// Top level of the class priority call queue: cell chain, class counters, result register.
//
// Usage:
//   req carries one command per beat: insert a call, serve the head call, or
//   dismiss the lowest class held (data if any, else voice). rsp returns
//   exactly one result beat per command, with status and the new occupancy.
//   Calls sit in a chain of CAPACITY cells kept sorted by class, emergency
//   first, FIFO within a class. On insert every cell compares its class with
//   the new call at once and either holds, loads the call, or takes its left
//   neighbor; on serve every cell takes its right neighbor. Dismiss only
//   lowers the held count using per-class counters.
//   Result: registered, so it appears in the cycle after the command beat.
//   Throughput: one command per cycle while each result is taken at once.
//   Stall: while a result waits unread req.ready drops, so the block holds
//   at most one result; ready returns in the cycle rsp is taken.
//   Reset: rst (synchronous) empties the queue and drops rsp.valid; the
//   cell contents are not cleared and are never read until written.
module class_priority_call_queue_core
  import cpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  cpq_req_if.sink   req,
  cpq_rsp_if.source rsp
);

  logic [CNT_W-1:0] held, held_next;
  logic [CNT_W-1:0] cnt_e, cnt_e_next;
  logic [CNT_W-1:0] cnt_v, cnt_v_next;
  logic [CNT_W-1:0] cnt_d, cnt_d_next;

  logic       fire;
  logic [1:0] ins_cls;
  logic       full;

  cell_ctrl_t ctrl;
  call_rec_t  cell_rec [CAPACITY];
  logic       cell_ge  [CAPACITY];
  logic       occ      [CAPACITY];

  logic [1:0]  status_next;
  logic [1:0]  class_next;
  call_rec_t   head_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign ins_cls   = (req.call_class > CLASS_EMERG) ? CLASS_DATA : req.call_class;
  assign full      = (held == CNT_W'(CAPACITY));

  always_comb begin
    ctrl.insert          = fire && (req.cmd == CMD_INSERT) && !full;
    ctrl.serve           = fire && (req.cmd == CMD_SERVE) && (held != '0);
    ctrl.rec.cls         = ins_cls;
    ctrl.rec.sender      = req.sender_id;
    ctrl.rec.receiver    = req.receiver_id;
    ctrl.rec.packets     = req.packet_count;
    ctrl.rec.show_caller = req.show_caller;
    ctrl.rec.roaming     = req.roaming_on;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = held > CNT_W'(g);
    cpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[g]),
      .left_ge   ((g == 0) ? 1'b1 : cell_ge[(g == 0) ? 0 : g - 1]),
      .left_rec  ((g == 0) ? ctrl.rec : cell_rec[(g == 0) ? 0 : g - 1]),
      .right_rec (cell_rec[(g == CAPACITY - 1) ? g : g + 1]),
      .rec       (cell_rec[g]),
      .ge        (cell_ge[g])
    );
  end

  always_comb begin
    held_next   = held;
    cnt_e_next  = cnt_e;
    cnt_v_next  = cnt_v;
    cnt_d_next  = cnt_d;
    status_next = STATUS_OK;
    class_next  = CLASS_DATA;
    head_next   = '0;
    case (req.cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          held_next = held + CNT_W'(1);
          case (ins_cls)
            CLASS_EMERG: cnt_e_next = cnt_e + CNT_W'(1);
            CLASS_VOICE: cnt_v_next = cnt_v + CNT_W'(1);
            default:     cnt_d_next = cnt_d + CNT_W'(1);
          endcase
        end
      end
      CMD_SERVE: begin
        if (held == '0) begin
          status_next = STATUS_EMPTY;
        end else begin
          head_next  = cell_rec[0];
          class_next = cell_rec[0].cls;
          held_next  = held - CNT_W'(1);
          case (cell_rec[0].cls)
            CLASS_EMERG: cnt_e_next = cnt_e - CNT_W'(1);
            CLASS_VOICE: cnt_v_next = cnt_v - CNT_W'(1);
            default:     cnt_d_next = cnt_d - CNT_W'(1);
          endcase
        end
      end
      CMD_DISMISS: begin
        if (held == '0) begin
          status_next = STATUS_EMPTY;
        end else if (cnt_d != '0) begin
          held_next  = held - cnt_d;
          cnt_d_next = '0;
          class_next = CLASS_DATA;
        end else if (cnt_v != '0) begin
          held_next  = held - cnt_v;
          cnt_v_next = '0;
          class_next = CLASS_VOICE;
        end else begin
          status_next = STATUS_NOTHING;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      cnt_e     <= '0;
      cnt_v     <= '0;
      cnt_d     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        held  <= held_next;
        cnt_e <= cnt_e_next;
        cnt_v <= cnt_v_next;
        cnt_d <= cnt_d_next;
      end
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status          <= status_next;
      rsp.out_class       <= class_next;
      rsp.out_sender      <= head_next.sender;
      rsp.out_receiver    <= head_next.receiver;
      rsp.out_packets     <= head_next.packets;
      rsp.out_show_caller <= head_next.show_caller;
      rsp.out_roaming     <= head_next.roaming;
      rsp.occupancy       <= OCC_W'(held_next);
    end
  end

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 2)'(held) == (CNT_W + 2)'(cnt_e) + (CNT_W + 2)'(cnt_v) + (CNT_W + 2)'(cnt_d))
    else $error("held count differs from sum of class counts");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_insert: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> held == $past(held) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_serve: assert property (@(posedge clk) disable iff (rst)
    ctrl.serve |=> (rsp.status == STATUS_OK) && (held == $past(held) - CNT_W'(1)))
    else $error("serve did not shrink the queue");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (held > CNT_W'(1)) |-> (cell_rec[0].cls >= cell_rec[1].cls))
    else $error("head cells out of class order");

endmodule

FILE: design/cpq_cell.sv
// One slot of the sorted call chain: keeps, loads the new call, or shifts.
module cpq_cell
  import cpq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       left_ge,
  input  call_rec_t  left_rec,
  input  call_rec_t  right_rec,
  output call_rec_t  rec,
  output logic       ge
);

  // held and ranked at or above the incoming class
  assign ge = occ && (rec.cls >= ctrl.rec.cls);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!ge) begin
        rec <= left_ge ? ctrl.rec : left_rec;
      end
    end else if (ctrl.serve) begin
      rec <= right_rec;
    end
  end

endmodule
